[src/i2cras_pkg.sv]
// Shared types and codes for the I2C register access sequencer.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package i2cras_pkg;

  // Request and event codes on the input channel
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Bus engine commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RACK  = 3'd3;
  localparam logic [2:0] CMD_RNACK = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  // Transaction result codes
  localparam logic [2:0] RES_OK          = 3'd0;
  localparam logic [2:0] RES_START_FAIL  = 3'd1;
  localparam logic [2:0] RES_ADDR_BAD    = 3'd2;
  localparam logic [2:0] RES_NACK        = 3'd3;
  localparam logic [2:0] RES_RESTART_FAIL = 3'd4;
  localparam logic [2:0] RES_RADDR_NACK  = 3'd5;
  localparam logic [2:0] RES_WRITE_FAIL  = 3'd6;

  // Engine status codes, low three bits masked off
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] device_address;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic [2:0] result_code;
  } out_item_t;

endpackage

`default_nettype wire

[src/i2cras_if.sv]
// Valid/ready channel interfaces for the sequencer's request and result sides.
// Depends on i2cras_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface i2cras_in_if;
  logic                 valid;
  logic                 ready;
  i2cras_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cras_out_if;
  logic                  valid;
  logic                  ready;
  i2cras_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/i2cras_in_stage.sv]
// Input register of the sequencer: holds one accepted request or event.
// Depends on i2cras_pkg and i2cras_in_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cras_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  i2cras_in_if.sink                 in_ch,
  input  wire logic                 take,
  output      logic                 item_vld,
  output      i2cras_pkg::in_item_t item
);

  logic                 vld_r;
  logic                 vld_nxt;
  i2cras_pkg::in_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ch.ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.valid && in_ch.ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.data;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

[src/i2cras_seq.sv]
// Transaction sequencer: phase state machine, saved request fields and the
// result register. Depends on i2cras_pkg and i2cras_out_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cras_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_vld,
  input  wire i2cras_pkg::in_item_t item,
  output      logic                 take,
  i2cras_out_if.source              out_ch
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_R_START,
    PH_R_SLAW,
    PH_R_REG,
    PH_R_RESTART,
    PH_R_SLAR,
    PH_R_DATA,
    PH_W_START,
    PH_W_SLAW,
    PH_W_REG,
    PH_W_DATA
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  is_write_r, is_write_nxt;
  logic [6:0]            device_r, device_nxt;
  logic [7:0]            register_r, register_nxt;
  logic [7:0]            data_r, data_nxt;
  logic [7:0]            remaining_r, remaining_nxt;
  logic [7:0]            index_r, index_nxt;
  logic                  out_vld_r;
  i2cras_pkg::out_item_t out_r, out_nxt;

  logic [7:0] st;
  logic [7:0] idx_inc;
  logic [7:0] idx_inc2;

  assign take = item_vld && (!out_vld_r || out_ch.ready);

  assign st       = item.bus_status & i2cras_pkg::ST_MASK;
  assign idx_inc  = index_r + 8'd1;
  assign idx_inc2 = index_r + 8'd2;

  always_comb begin
    phase_nxt     = phase_r;
    is_write_nxt  = is_write_r;
    device_nxt    = device_r;
    register_nxt  = register_r;
    data_nxt      = data_r;
    remaining_nxt = remaining_r;
    index_nxt     = index_r;
    out_nxt       = '0;

    if (item.opcode == i2cras_pkg::OP_READ || item.opcode == i2cras_pkg::OP_WRITE) begin
      // requests while a transaction runs are dropped
      if (phase_r == PH_IDLE) begin
        device_nxt      = item.device_address;
        register_nxt    = item.reg_address;
        data_nxt        = item.write_data;
        remaining_nxt   = item.byte_count;
        index_nxt       = 8'd0;
        is_write_nxt    = (item.opcode == i2cras_pkg::OP_WRITE);
        phase_nxt       = (item.opcode == i2cras_pkg::OP_WRITE) ? PH_W_START : PH_R_START;
        out_nxt.command = i2cras_pkg::CMD_START;
      end
    end else if (item.opcode == i2cras_pkg::OP_EVENT) begin
      case (phase_r)
        PH_R_START: begin
          if (st != i2cras_pkg::ST_START) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_START_FAIL;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = {device_r, 1'b0};
            phase_nxt       = PH_R_SLAW;
          end
        end
        PH_R_SLAW: begin
          if (st != i2cras_pkg::ST_SLAW_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = (st == i2cras_pkg::ST_SLAW_NACK) ?
                                  i2cras_pkg::RES_NACK : i2cras_pkg::RES_ADDR_BAD;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = register_r;
            phase_nxt       = PH_R_REG;
          end
        end
        PH_R_REG: begin
          if (st != i2cras_pkg::ST_DATA_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_NACK;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_START;
            phase_nxt       = PH_R_RESTART;
          end
        end
        PH_R_RESTART: begin
          if (st != i2cras_pkg::ST_RESTART) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_RESTART_FAIL;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = {device_r, 1'b1};
            phase_nxt       = PH_R_SLAR;
          end
        end
        PH_R_SLAR: begin
          if (st != i2cras_pkg::ST_SLAR_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_RADDR_NACK;
            phase_nxt           = PH_IDLE;
          end else begin
            index_nxt = 8'd0;
            if (remaining_r == 8'd0) begin
              // nothing to read: stop straight away
              out_nxt.command  = i2cras_pkg::CMD_STOP;
              out_nxt.done_res = 1'b1;
              phase_nxt        = PH_IDLE;
            end else begin
              out_nxt.command = (remaining_r == 8'd1) ?
                                i2cras_pkg::CMD_RNACK : i2cras_pkg::CMD_RACK;
              phase_nxt       = PH_R_DATA;
            end
          end
        end
        PH_R_DATA: begin
          // receive completions carry no status check
          out_nxt.rx_data  = item.received_byte;
          out_nxt.rx_valid = 1'b1;
          index_nxt        = idx_inc;
          if (idx_inc == remaining_r) begin
            out_nxt.rx_last  = 1'b1;
            out_nxt.command  = i2cras_pkg::CMD_STOP;
            out_nxt.done_res = 1'b1;
            phase_nxt        = PH_IDLE;
          end else begin
            out_nxt.command = (idx_inc2 == remaining_r) ?
                              i2cras_pkg::CMD_RNACK : i2cras_pkg::CMD_RACK;
          end
        end
        PH_W_START: begin
          if (st != i2cras_pkg::ST_START) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_WRITE_FAIL;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = {device_r, 1'b0};
            phase_nxt       = PH_W_SLAW;
          end
        end
        PH_W_SLAW: begin
          if (st != i2cras_pkg::ST_SLAW_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_WRITE_FAIL;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = register_r;
            phase_nxt       = PH_W_REG;
          end
        end
        PH_W_REG: begin
          if (st != i2cras_pkg::ST_DATA_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_WRITE_FAIL;
            phase_nxt           = PH_IDLE;
          end else begin
            out_nxt.command = i2cras_pkg::CMD_SEND;
            out_nxt.tx_byte = data_r;
            phase_nxt       = PH_W_DATA;
          end
        end
        PH_W_DATA: begin
          if (st != i2cras_pkg::ST_DATA_ACK) begin
            out_nxt.done_res    = 1'b1;
            out_nxt.result_code = i2cras_pkg::RES_WRITE_FAIL;
          end else begin
            out_nxt.command  = i2cras_pkg::CMD_STOP;
            out_nxt.rx_data  = data_r;
            out_nxt.done_res = 1'b1;
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_write_r  <= 1'b0;
      device_r    <= '0;
      register_r  <= '0;
      data_r      <= '0;
      remaining_r <= '0;
      index_r     <= '0;
      out_vld_r   <= 1'b0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      is_write_r  <= is_write_nxt;
      device_r    <= device_nxt;
      register_r  <= register_nxt;
      data_r      <= data_nxt;
      remaining_r <= remaining_nxt;
      index_r     <= index_nxt;
      out_vld_r   <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r   <= 1'b0;
    end
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire

[src/i2c_register_access_sequencer_core.sv]
// I2C register access sequencer: top level wiring of input stage and sequencer.
// Depends on i2cras_pkg, i2cras_if, i2cras_in_stage and i2cras_seq.
//
// Usage: in_ch carries read/write requests and bus engine completion events
// (status byte plus any received byte). Every transfer on in_ch produces
// exactly one transfer on out_ch: the next engine command (start, send byte,
// receive with ACK/NACK, stop or none), the received byte when there is one,
// and a done flag with result code when the transaction ends. Requests that
// arrive mid-transaction and events while idle give a command of none.
// Each in_ch item is first held in the input register; the phase logic then
// loads the result register, which drives out_ch.valid and out_ch.data.
// Throughput is one item per cycle while out_ch is ready; the phase update is
// combinational logic between the two registers. When out_ch is stalled the
// result register holds and the input register takes one more item, after
// which in_ch.ready drops until out_ch drains. Reset (rst_n low, synchronous)
// empties both registers and returns the sequencer to idle with all saved
// fields cleared.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_sequencer_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  i2cras_in_if.sink    in_ch,
  i2cras_out_if.source out_ch
);

  logic                 item_vld;
  logic                 take;
  i2cras_pkg::in_item_t item;

  i2cras_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  i2cras_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[src/i2cras_chk.sv]
// Port-level checks for the I2C register access sequencer, bound to the top.
// Depends on i2cras_pkg and i2c_register_access_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none

module i2cras_chk (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire i2cras_pkg::out_item_t out_data
);

  // A stalled result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing is shown the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // An error ends the transaction with no stop and no command
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_code != i2cras_pkg::RES_OK |->
      out_data.done_res && out_data.command == i2cras_pkg::CMD_NONE)
    else $error("error result without done or with a command");

  // Last received byte closes the read with a stop
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_last |->
      out_data.rx_valid && out_data.done_res &&
      out_data.command == i2cras_pkg::CMD_STOP)
    else $error("last byte without stop and done");

endmodule

bind i2c_register_access_sequencer_core i2cras_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

[tb/i2c_register_access_sequencer_core_tb.sv]
// Self-checking testbench for the I2C register access sequencer core.
// Depends on i2cras_pkg, i2cras_if and the core; predicts each result from its own phase model.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_core_tb;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         ITEMS_TARGET = 1900;
  localparam int         CYCLE_LIMIT  = 1000000;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_R_START, SQ_R_SLAW, SQ_R_REG, SQ_R_RESTART, SQ_R_SLAR, SQ_R_DATA,
    SQ_W_START, SQ_W_SLAW, SQ_W_REG, SQ_W_DATA
  } seq_phase_t;

  logic clk;
  logic rst_n;

  i2cras_in_if  in_ch ();
  i2cras_out_if out_ch ();

  i2c_register_access_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // sequencer model state
  seq_phase_t sq_phase;
  logic [6:0] sq_dev;
  logic [7:0] sq_reg;
  logic [7:0] sq_wdata;
  logic [7:0] sq_count;
  logic [7:0] sq_index;

  i2cras_pkg::out_item_t pending_results[$];
  int         err_count;
  int         sent_count;
  int         result_count;
  int         useful_items;
  int         txn_count;
  int         closed_ok;
  int         closed_err;
  int         burst_left;
  int         cycles;

  int         rx_mode;
  int         rx_mode_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: stall pattern is redrawn whenever its random countdown runs out
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(32, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= ((cycles % 5) < 2);
      default: out_ch.ready <= ((cycles % 24) >= 18);
    endcase
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic void close_txn(inout i2cras_pkg::out_item_t r,
                                    input logic [2:0] code);
    r.done_res    = 1'b1;
    r.result_code = code;
    sq_phase      = SQ_IDLE;
  endfunction

  function automatic logic [2:0] recv_command(input logic [7:0] idx);
    return (idx + 8'd1 == sq_count) ? i2cras_pkg::CMD_RNACK : i2cras_pkg::CMD_RACK;
  endfunction

  // one result per accepted item; advances the model state
  function automatic i2cras_pkg::out_item_t next_bus_step(input i2cras_pkg::in_item_t it);
    i2cras_pkg::out_item_t r;
    logic [7:0]            st;
    r  = '0;
    st = it.bus_status & i2cras_pkg::ST_MASK;
    if (it.opcode == i2cras_pkg::OP_READ || it.opcode == i2cras_pkg::OP_WRITE) begin
      if (sq_phase == SQ_IDLE) begin
        sq_dev    = it.device_address;
        sq_reg    = it.reg_address;
        sq_wdata  = it.write_data;
        sq_count  = it.byte_count;
        sq_index  = 8'd0;
        sq_phase  = (it.opcode == i2cras_pkg::OP_WRITE) ? SQ_W_START : SQ_R_START;
        r.command = i2cras_pkg::CMD_START;
      end
    end else if (it.opcode == i2cras_pkg::OP_EVENT) begin
      case (sq_phase)
        SQ_R_START: if (st != i2cras_pkg::ST_START) close_txn(r, i2cras_pkg::RES_START_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = {sq_dev, 1'b0};
            sq_phase  = SQ_R_SLAW;
          end
        SQ_R_SLAW: if (st != i2cras_pkg::ST_SLAW_ACK)
            close_txn(r, (st == i2cras_pkg::ST_SLAW_NACK) ? i2cras_pkg::RES_NACK
                                                           : i2cras_pkg::RES_ADDR_BAD);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = sq_reg;
            sq_phase  = SQ_R_REG;
          end
        SQ_R_REG: if (st != i2cras_pkg::ST_DATA_ACK) close_txn(r, i2cras_pkg::RES_NACK);
          else begin
            r.command = i2cras_pkg::CMD_START;
            sq_phase  = SQ_R_RESTART;
          end
        SQ_R_RESTART: if (st != i2cras_pkg::ST_RESTART)
            close_txn(r, i2cras_pkg::RES_RESTART_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = {sq_dev, 1'b1};
            sq_phase  = SQ_R_SLAR;
          end
        SQ_R_SLAR: if (st != i2cras_pkg::ST_SLAR_ACK)
            close_txn(r, i2cras_pkg::RES_RADDR_NACK);
          else begin
            sq_index = 8'd0;
            if (sq_count == 8'd0) begin
              r.command = i2cras_pkg::CMD_STOP;
              close_txn(r, i2cras_pkg::RES_OK);
            end else begin
              r.command = recv_command(sq_index);
              sq_phase  = SQ_R_DATA;
            end
          end
        SQ_R_DATA: begin
          // status is not checked on receive completions
          r.rx_data  = it.received_byte;
          r.rx_valid = 1'b1;
          if (sq_index + 8'd1 == sq_count) begin
            r.rx_last = 1'b1;
            r.command = i2cras_pkg::CMD_STOP;
            sq_index  = sq_index + 8'd1;
            close_txn(r, i2cras_pkg::RES_OK);
          end else begin
            sq_index  = sq_index + 8'd1;
            r.command = recv_command(sq_index);
          end
        end
        SQ_W_START: if (st != i2cras_pkg::ST_START) close_txn(r, i2cras_pkg::RES_WRITE_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = {sq_dev, 1'b0};
            sq_phase  = SQ_W_SLAW;
          end
        SQ_W_SLAW: if (st != i2cras_pkg::ST_SLAW_ACK)
            close_txn(r, i2cras_pkg::RES_WRITE_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = sq_reg;
            sq_phase  = SQ_W_REG;
          end
        SQ_W_REG: if (st != i2cras_pkg::ST_DATA_ACK)
            close_txn(r, i2cras_pkg::RES_WRITE_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_SEND;
            r.tx_byte = sq_wdata;
            sq_phase  = SQ_W_DATA;
          end
        SQ_W_DATA: if (st != i2cras_pkg::ST_DATA_ACK)
            close_txn(r, i2cras_pkg::RES_WRITE_FAIL);
          else begin
            r.command = i2cras_pkg::CMD_STOP;
            r.rx_data = sq_wdata;
            close_txn(r, i2cras_pkg::RES_OK);
          end
        default: ;
      endcase
    end
    return r;
  endfunction

  // monitor: check results first, then log the new input transfer
  always @(posedge clk) begin : bus_monitor
    i2cras_pkg::out_item_t want;
    i2cras_pkg::out_item_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        result_count++;
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (want.done_res) begin
            if (want.result_code == i2cras_pkg::RES_OK) closed_ok++;
            else closed_err++;
          end
          compare_field("command", 8'(got.command), 8'(want.command));
          compare_field("tx_byte", got.tx_byte, want.tx_byte);
          compare_field("rx_data", got.rx_data, want.rx_data);
          compare_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
          compare_field("rx_last", 8'(got.rx_last), 8'(want.rx_last));
          compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
          compare_field("result_code", 8'(got.result_code), 8'(want.result_code));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(next_bus_step(in_ch.data));
    end
  end

  // sender: bursts of random length separated by random gaps
  task automatic send_item(input i2cras_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    sent_count++;
  endtask

  function automatic i2cras_pkg::in_item_t rand_item();
    i2cras_pkg::in_item_t it;
    it.opcode         = 2'($urandom_range(0, 3));
    it.device_address = 7'($urandom_range(0, 127));
    it.reg_address    = 8'($urandom_range(0, 255));
    it.write_data     = 8'($urandom_range(0, 255));
    it.byte_count     = 8'($urandom_range(0, 255));
    it.bus_status     = 8'($urandom_range(0, 255));
    it.received_byte  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic i2cras_pkg::in_item_t make_request(input logic [1:0] op,
                                                        input logic [6:0] dev,
                                                        input logic [7:0] regi,
                                                        input logic [7:0] wdata,
                                                        input logic [7:0] cnt);
    i2cras_pkg::in_item_t it;
    it                = '0;
    it.opcode         = op;
    it.device_address = dev;
    it.reg_address    = regi;
    it.write_data     = wdata;
    it.byte_count     = cnt;
    return it;
  endfunction

  function automatic i2cras_pkg::in_item_t make_event(input logic [7:0] status,
                                                      input logic [7:0] rx);
    i2cras_pkg::in_item_t it;
    it               = '0;
    it.opcode        = i2cras_pkg::OP_EVENT;
    it.bus_status    = status;
    it.received_byte = rx;
    return it;
  endfunction

  function automatic logic [7:0] status_for(input logic wr, input int step);
    case (step)
      1:       return i2cras_pkg::ST_START;
      2:       return i2cras_pkg::ST_SLAW_ACK;
      3:       return i2cras_pkg::ST_DATA_ACK;
      4:       return wr ? i2cras_pkg::ST_DATA_ACK : i2cras_pkg::ST_RESTART;
      default: return i2cras_pkg::ST_SLAR_ACK;
    endcase
  endfunction

  function automatic logic [7:0] wrong_status(input logic [7:0] good);
    logic [7:0] s;
    logic [7:0] low;
    low = 8'($urandom_range(0, 7));
    if (good == i2cras_pkg::ST_SLAW_ACK && $urandom_range(0, 1))
      return i2cras_pkg::ST_SLAW_NACK | low;
    do s = 8'($urandom_range(0, 255)); while ((s & i2cras_pkg::ST_MASK) == good);
    return s;
  endfunction

  // items the block should ignore: requests while busy, events while idle, unused opcode
  task automatic send_noise(input logic busy);
    i2cras_pkg::in_item_t it;
    it = rand_item();
    if ($urandom_range(0, 2) == 0) it.opcode = OP_UNUSED;
    else if (busy) it.opcode = $urandom_range(0, 1) ? i2cras_pkg::OP_WRITE
                                                    : i2cras_pkg::OP_READ;
    else it.opcode = i2cras_pkg::OP_EVENT;
    send_item(it);
  endtask

  // well-formed transaction with random content; fail_at names the event given a bad status
  task automatic run_txn(input logic wr, input int count, input int fail_at,
                         input int noise_pct);
    i2cras_pkg::in_item_t it;
    int                   steps;
    int                   checked;
    logic [7:0]           good;
    it        = rand_item();
    it.opcode = wr ? i2cras_pkg::OP_WRITE : i2cras_pkg::OP_READ;
    if (!wr) it.byte_count = count[7:0];
    send_item(it);
    useful_items++;
    checked = wr ? 4 : 5;
    steps   = wr ? 4 : 5 + count;
    for (int s = 1; s <= steps; s++) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise(1'b1);
      it        = rand_item();
      it.opcode = i2cras_pkg::OP_EVENT;
      if (s <= checked) begin
        good          = status_for(wr, s);
        it.bus_status = (s == fail_at) ? wrong_status(good)
                                       : (good | {5'd0, it.bus_status[2:0]});
      end
      send_item(it);
      useful_items++;
      if (s == fail_at) break;
    end
    txn_count++;
  endtask

  task automatic test_idle_noise;
    send_item(make_event(i2cras_pkg::ST_START, 8'h5A));
    send_item({OP_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_write_extremes;
    send_item(make_request(i2cras_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'h00));
    send_item(make_event(i2cras_pkg::ST_START | 8'h07, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAW_ACK, 8'h00));
    send_item(make_event(i2cras_pkg::ST_DATA_ACK | 8'h07, 8'h00));
    send_item(make_event(i2cras_pkg::ST_DATA_ACK, 8'h00));
    txn_count++;
  endtask

  task automatic test_read_zero_count;
    send_item(make_request(i2cras_pkg::OP_READ, 7'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_event(i2cras_pkg::ST_START, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAW_ACK, 8'h00));
    send_item(make_event(i2cras_pkg::ST_DATA_ACK, 8'h00));
    send_item(make_event(i2cras_pkg::ST_RESTART, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAR_ACK, 8'h00));
    txn_count++;
  endtask

  task automatic test_read_two_bytes;
    send_item(make_request(i2cras_pkg::OP_READ, 7'h7F, 8'h80, 8'h00, 8'h02));
    send_item(make_event(i2cras_pkg::ST_START, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAW_ACK, 8'h00));
    // request arriving mid-transaction is dropped
    send_item(make_request(i2cras_pkg::OP_WRITE, 7'h11, 8'h22, 8'h33, 8'h44));
    send_item(make_event(i2cras_pkg::ST_DATA_ACK, 8'h00));
    send_item(make_event(i2cras_pkg::ST_RESTART, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAR_ACK | 8'h07, 8'h00));
    send_item(make_event(8'hFF, 8'h00));
    send_item(make_event(8'h00, 8'hFF));
    txn_count++;
  endtask

  task automatic test_read_addr_nack;
    send_item(make_request(i2cras_pkg::OP_READ, 7'h55, 8'h0F, 8'h00, 8'h03));
    send_item(make_event(i2cras_pkg::ST_START, 8'h00));
    send_item(make_event(i2cras_pkg::ST_SLAW_NACK, 8'h00));
    txn_count++;
  endtask

  task automatic test_error_paths;
    for (int wr = 0; wr < 2; wr++)
      for (int s = 1; s <= (wr ? 4 : 5); s++)
        repeat (3) run_txn(wr[0], $urandom_range(0, 3), s, 5);
  endtask

  task automatic test_long_reads;
    run_txn(1'b0, 255, 0, 2);
    run_txn(1'b0, 128, 0, 2);
  endtask

  task automatic test_random_mix;
    logic wr;
    int   pick;
    int   cnt;
    int   fail;
    while (sent_count < ITEMS_TARGET) begin
      wr   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      cnt  = (pick < 80) ? $urandom_range(0, 4)
           : (pick < 98) ? $urandom_range(5, 20) : $urandom_range(100, 255);
      fail = ($urandom_range(0, 99) < 20) ? $urandom_range(1, wr ? 4 : 5) : 0;
      run_txn(wr, cnt, fail, 8);
      if ($urandom_range(0, 99) < 15) send_noise(1'b0);
    end
  endtask

  task automatic wait_drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    sq_phase     = SQ_IDLE;
    sq_dev       = '0;
    sq_reg       = '0;
    sq_wdata     = '0;
    sq_count     = '0;
    sq_index     = '0;
    err_count    = 0;
    sent_count   = 0;
    result_count = 0;
    useful_items = 0;
    txn_count    = 0;
    closed_ok    = 0;
    closed_err   = 0;
    burst_left   = 0;
    cycles       = 0;
    rx_mode      = 0;
    rx_mode_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_noise();
    test_write_extremes();
    test_read_zero_count();
    test_read_two_bytes();
    test_read_addr_nack();
    test_error_paths();
    test_long_reads();
    test_random_mix();
    wait_drain();

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Ran %0d transactions over %0d input transfers, %0d results checked",
             txn_count, sent_count, result_count);
    $display("Closed %0d ok and %0d on error, %0d mismatches", closed_ok, closed_err,
             err_count);
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
